// File: src/deflate_lz77_token_expander_defines.svh
// assertion macros shared by the token expander rtl
`ifndef DEFLATE_LZ77_TOKEN_EXPANDER_DEFINES_SVH
`define DEFLATE_LZ77_TOKEN_EXPANDER_DEFINES_SVH

// same-cycle implication under reset
`define DLZE_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define DLZE_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/dlze_pkg.sv
// types and constants of the lz77 token expander
`timescale 1ns / 1ps

package dlze_pkg;

    localparam int unsigned ALU_W = 33;
    localparam logic [8:0] MAX_MATCH = 9'd258;

    typedef enum logic [1:0] {
        OP_LITERAL = 2'd0,
        OP_MATCH   = 2'd1,
        OP_END     = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_EOB      = 2'd1,
        STATUS_BAD_DIST = 2'd2,
        STATUS_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LIT,
        ST_DIST,
        ST_SUM,
        ST_CAP,
        ST_SRC,
        ST_WRAP,
        ST_COPY,
        ST_EMIT
    } state_t;

    // request from the sequencer to the output packer
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] byte_data;
        logic       byte_last;
        logic       flush_valid;
        status_t    status;
    } pk_in_t;

endpackage

// File: src/dlze_alu.sv
// shared 33-bit add/subtract unit used by the sequencer for its capacity, distance and index arithmetic
`timescale 1ns / 1ps

module dlze_alu
    import dlze_pkg::*;
(
    input  logic [ALU_W-1:0] a,
    input  logic [ALU_W-1:0] b,
    input  alu_op_t          op,
    output logic [ALU_W-1:0] res,
    output logic             carry
);

    logic [ALU_W-1:0] b_eff;
    logic [ALU_W:0]   sum;

    // subtract as a + ~b + 1; carry high means no borrow
    assign b_eff = (op == ALU_SUB) ? ~b : b;
    assign sum   = {1'b0, a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, (op == ALU_SUB)};
    assign res   = sum[ALU_W-1:0];
    assign carry = sum[ALU_W];

endmodule

// File: src/dlze_window.sv
// history window memory, one write and one registered read per cycle
`timescale 1ns / 1ps

module dlze_window #(
    parameter int unsigned WINDOW_BYTES = 32768
) (
    input  logic                            clk,
    input  logic                            we,
    input  logic [$clog2(WINDOW_BYTES)-1:0] waddr,
    input  logic [7:0]                      wdata,
    input  logic                            re,
    input  logic [$clog2(WINDOW_BYTES)-1:0] raddr,
    output logic [7:0]                      rdata
);

    logic [7:0] mem [WINDOW_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/dlze_packer.sv
// packs literal and copied bytes into output words, emits status words and holds the output register
`timescale 1ns / 1ps

module dlze_packer
    import dlze_pkg::*;
#(
    parameter int unsigned LANE_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  pk_in_t      pk_in,
    output logic        out_free,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] data_bytes,
    output logic [3:0]  byte_count,
    output logic        last,
    output logic [1:0]  status
);

    localparam int unsigned LW = $clog2(LANE_BYTES + 1);

    logic [63:0]   acc_reg, acc_next;
    logic [LW-1:0] lane_reg, lane_next;
    logic          out_valid_reg, out_valid_next;
    logic [63:0]   data_reg, data_next;
    logic [3:0]    count_reg, count_next;
    logic          last_reg, last_next;
    status_t       status_reg, status_next;
    logic [63:0]   merged;

    assign out_free = !out_valid_reg || !out_stall;
    assign merged   = acc_reg | (64'(pk_in.byte_data) << {lane_reg, 3'b000});

    always_comb
    begin
        acc_next       = acc_reg;
        lane_next      = lane_reg;
        data_next      = data_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (pk_in.flush_valid)
        begin
            data_next      = 64'd0;
            count_next     = 4'd0;
            last_next      = 1'b1;
            status_next    = pk_in.status;
            out_valid_next = 1'b1;
        end
        else if (pk_in.byte_valid)
        begin
            if (pk_in.byte_last || (lane_reg == LW'(LANE_BYTES - 1)))
            begin
                data_next      = merged;
                count_next     = 4'(lane_reg) + 4'd1;
                last_next      = pk_in.byte_last;
                status_next    = STATUS_OK;
                out_valid_next = 1'b1;
                acc_next       = 64'd0;
                lane_next      = '0;
            end
            else
            begin
                acc_next  = merged;
                lane_next = lane_reg + LW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 64'd0;
            lane_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            lane_reg      <= lane_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        count_reg  <= count_next;
        last_reg   <= last_next;
        status_reg <= status_next;
    end

    assign out_valid  = out_valid_reg;
    assign data_bytes = data_reg;
    assign byte_count = count_reg;
    assign last       = last_reg;
    assign status     = status_reg;

endmodule

// File: src/deflate_lz77_token_expander.sv
// lz77 token expander top level: sequencer, window, shared alu and packer
// Usage:
//  Input channel (in_valid/in_stall) takes one decoded token per word:
//  opcode, literal_byte, match_length, match_distance. in_stall is high
//  while a token is being worked on; the next token enters once it is done.
//  Output channel (out_valid/out_stall) delivers result words: up to
//  LANE_BYTES bytes in data_bytes, byte_count, last and status.
//  A literal, end of block or error result is written into the packer's output
//  register once the output is free. A match first runs the distance, sum,
//  capacity, source and wrap steps on the shared adder, then copies one window
//  byte per cycle while the output is free.
//  The single byte-wide window read port sets the copy rate.
//  A stalled output word is held; the copy loop pauses until it is taken.
//  Reset clears position and the output valid flag and sets output_capacity
//  to all ones. The window is not cleared; only written entries are read.
//  output_capacity is written over apb address 0; the user must do so only while idle, the block does not check.
`timescale 1ns / 1ps
`include "deflate_lz77_token_expander_defines.svh"

module deflate_lz77_token_expander
    import dlze_pkg::*;
#(
    parameter int unsigned WINDOW_BYTES = 32768,
    parameter int unsigned LANE_BYTES   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  literal_byte,
    input  logic [8:0]  match_length,
    input  logic [15:0] match_distance,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] data_bytes,
    output logic [3:0]  byte_count,
    output logic        last,
    output logic [1:0]  status
);

    localparam int unsigned AW = $clog2(WINDOW_BYTES);

    state_t           state_reg, state_next;
    logic [31:0]      cap_reg, cap_next;
    logic [31:0]      pos_reg, pos_next;
    logic [AW-1:0]    wpos_reg, wpos_next;
    logic [7:0]       lit_reg, lit_next;
    logic [8:0]       len_reg, len_next;
    logic [15:0]      dist_reg, dist_next;
    logic [ALU_W-1:0] sum_reg, sum_next;
    logic [ALU_W-1:0] diff_reg, diff_next;
    logic             borrow_reg, borrow_next;
    logic [AW-1:0]    rd_reg, rd_next;
    logic [8:0]       issued_reg, issued_next;
    logic [8:0]       done_reg, done_next;
    logic             pending_reg, pending_next;
    logic [7:0]       prev_reg, prev_next;
    status_t          status_reg, status_next;

    logic [ALU_W-1:0] alu_a, alu_b, alu_res;
    alu_op_t          alu_op;
    logic             alu_carry;

    logic             mem_we, mem_re;
    logic [7:0]       mem_wdata, mem_rdata;
    logic [7:0]       cp_byte;
    logic             out_free;
    logic             in_accept;
    logic             cfg_write;
    pk_in_t           pk;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == 2'd0);
    assign prdata    = (paddr == 2'd0) ? cap_reg : 32'd0;
    assign cap_next  = cfg_write ? pwdata : cap_reg;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    // overlap at distance one repeats the byte written just before
    assign cp_byte = ((dist_reg == 16'd1) && (done_reg != 9'd0)) ? prev_reg : mem_rdata;

    dlze_alu u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .op    (alu_op),
        .res   (alu_res),
        .carry (alu_carry)
    );

    dlze_window #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_window (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wpos_reg),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (rd_reg),
        .rdata (mem_rdata)
    );

    dlze_packer #(
        .LANE_BYTES (LANE_BYTES)
    ) u_packer (
        .clk        (clk),
        .rst_n      (rst_n),
        .pk_in      (pk),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_bytes (data_bytes),
        .byte_count (byte_count),
        .last       (last),
        .status     (status)
    );

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        wpos_next    = wpos_reg;
        lit_next     = lit_reg;
        len_next     = len_reg;
        dist_next    = dist_reg;
        sum_next     = sum_reg;
        diff_next    = diff_reg;
        borrow_next  = borrow_reg;
        rd_next      = rd_reg;
        issued_next  = issued_reg;
        done_next    = done_reg;
        pending_next = pending_reg;
        prev_next    = prev_reg;
        status_next  = status_reg;
        alu_a        = '0;
        alu_b        = '0;
        alu_op       = ALU_ADD;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_wdata    = cp_byte;
        pk           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    lit_next  = literal_byte;
                    len_next  = (match_length > MAX_MATCH) ? MAX_MATCH : match_length;
                    dist_next = match_distance;
                    unique case (opcode)
                        OP_LITERAL: state_next = ST_LIT;
                        OP_MATCH:   state_next = ST_DIST;
                        OP_END:
                        begin
                            status_next = STATUS_EOB;
                            state_next  = ST_EMIT;
                        end
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LIT:
            begin
                // pos - cap without borrow means the destination is full
                alu_a  = {1'b0, pos_reg};
                alu_b  = {1'b0, cap_reg};
                alu_op = ALU_SUB;
                if (alu_carry)
                begin
                    status_next = STATUS_FULL;
                    state_next  = ST_EMIT;
                end
                else if (out_free)
                begin
                    mem_we        = 1'b1;
                    mem_wdata     = lit_reg;
                    pos_next      = pos_reg + 32'd1;
                    wpos_next     = (wpos_reg == AW'(WINDOW_BYTES - 1)) ? '0 : wpos_reg + AW'(1);
                    pk.byte_valid = 1'b1;
                    pk.byte_data  = lit_reg;
                    pk.byte_last  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_DIST:
            begin
                alu_a  = {1'b0, pos_reg};
                alu_b  = ALU_W'(dist_reg);
                alu_op = ALU_SUB;
                if ((dist_reg == 16'd0) || ({1'b0, dist_reg} > 17'(WINDOW_BYTES)) || !alu_carry)
                begin
                    status_next = STATUS_BAD_DIST;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                alu_a      = {1'b0, pos_reg};
                alu_b      = ALU_W'(len_reg);
                alu_op     = ALU_ADD;
                sum_next   = alu_res;
                state_next = ST_CAP;
            end
            ST_CAP:
            begin
                alu_a  = {1'b0, cap_reg};
                alu_b  = sum_reg;
                alu_op = ALU_SUB;
                if (!alu_carry)
                begin
                    status_next = STATUS_FULL;
                    state_next  = ST_EMIT;
                end
                else if (len_reg == 9'd0)
                begin
                    status_next = STATUS_OK;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SRC;
                end
            end
            ST_SRC:
            begin
                alu_a       = ALU_W'(wpos_reg);
                alu_b       = ALU_W'(dist_reg);
                alu_op      = ALU_SUB;
                diff_next   = alu_res;
                borrow_next = !alu_carry;
                state_next  = ST_WRAP;
            end
            ST_WRAP:
            begin
                // fold a negative source index back into the window
                alu_a        = diff_reg;
                alu_b        = borrow_reg ? ALU_W'(WINDOW_BYTES) : '0;
                alu_op       = ALU_ADD;
                rd_next      = alu_res[AW-1:0];
                issued_next  = 9'd0;
                done_next    = 9'd0;
                pending_next = 1'b0;
                state_next   = ST_COPY;
            end
            ST_COPY:
            begin
                if (out_free)
                begin
                    pending_next = 1'b0;
                    if (issued_reg < len_reg)
                    begin
                        mem_re       = 1'b1;
                        rd_next      = (rd_reg == AW'(WINDOW_BYTES - 1)) ? '0 : rd_reg + AW'(1);
                        issued_next  = issued_reg + 9'd1;
                        pending_next = 1'b1;
                    end
                    if (pending_reg)
                    begin
                        mem_we        = 1'b1;
                        mem_wdata     = cp_byte;
                        prev_next     = cp_byte;
                        pos_next      = pos_reg + 32'd1;
                        wpos_next     = (wpos_reg == AW'(WINDOW_BYTES - 1)) ? '0
                                        : wpos_reg + AW'(1);
                        done_next     = done_reg + 9'd1;
                        pk.byte_valid = 1'b1;
                        pk.byte_data  = cp_byte;
                        pk.byte_last  = (done_reg + 9'd1 == len_reg);
                        if (done_reg + 9'd1 == len_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    pk.flush_valid = 1'b1;
                    pk.status      = status_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cap_reg     <= 32'hFFFF_FFFF;
            pos_reg     <= 32'd0;
            wpos_reg    <= '0;
            issued_reg  <= 9'd0;
            done_reg    <= 9'd0;
            pending_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            pos_reg     <= pos_next;
            wpos_reg    <= wpos_next;
            issued_reg  <= issued_next;
            done_reg    <= done_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lit_reg    <= lit_next;
        len_reg    <= len_next;
        dist_reg   <= dist_next;
        sum_reg    <= sum_next;
        diff_reg   <= diff_next;
        borrow_reg <= borrow_next;
        rd_reg     <= rd_next;
        prev_reg   <= prev_next;
        status_reg <= status_next;
    end

    `DLZE_ASSERT_IMPL(a_copy_inflight, clk, rst_n, state_reg == ST_COPY, issued_reg == done_reg + 9'(pending_reg), "copy reads and writes drifted apart")
    `DLZE_ASSERT_IMPL(a_copy_bound, clk, rst_n, state_reg == ST_COPY, done_reg < len_reg, "copy ran past its length")
    `DLZE_ASSERT_NEXT(a_copy_end, clk, rst_n, (state_reg == ST_COPY) && pk.byte_valid && pk.byte_last, state_reg == ST_IDLE, "copy did not finish after its last byte")

endmodule
